// File: rtl/psbr_pkg.sv
package psbr_pkg;

  localparam int SLOT_AW_MAX = 12;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_STALE     = 2'd1;
  localparam logic [1:0] ST_BEYOND    = 2'd2;
  localparam logic [1:0] ST_DUPLICATE = 2'd3;

  localparam logic [1:0] K_PARK    = 2'd0;
  localparam logic [1:0] K_DELIVER = 2'd1;
  localparam logic [1:0] K_ERROR   = 2'd2;
  localparam logic [1:0] K_DRAIN   = 2'd3;

  localparam logic [2:0] ADDR_NUM_SOURCES = 3'd0;
  localparam logic [4:0] NUM_SOURCES_RST  = 5'd16;

  typedef struct packed {
    logic [3:0]  source;
    logic [31:0] seq;
    logic        block_valid;
    logic [31:0] block_handle;
  } in_t;

  typedef struct packed {
    logic [3:0]  out_source;
    logic [31:0] out_handle;
    logic        out_is_close;
    logic        out_all_closed;
    logic [1:0]  out_status;
    logic        out_last;
  } out_t;

  typedef struct packed {
    logic [1:0]             kind;
    logic [3:0]             source;
    logic [31:0]            handle;
    logic                   is_close;
    logic [1:0]             status;
    logic                   last;
    logic [SLOT_AW_MAX-1:0] slot;
  } cmd_t;

  typedef struct packed {
    logic       we;
    logic [4:0] value;
  } cfg_wr_t;

endpackage

// File: rtl/psbr_queue.sv
module psbr_queue import psbr_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic not_empty,
  output cmd_t head
);

  cmd_t       ent_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign full      = (cnt_r == 2'd2);
  assign not_empty = (cnt_r != 2'd0);
  assign head      = ent_r[rp_r];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      ent_r[wp_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push && !full) wp_r <= ~wp_r;
      if (pop && not_empty) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'((push && !full) ? 1 : 0) - 2'((pop && not_empty) ? 1 : 0);
    end
  end

endmodule

// File: rtl/psbr_front.sv
module psbr_front import psbr_pkg::*; #(
  parameter int          MAX_SOURCES = 16,
  parameter int          WINDOW      = 16,
  parameter logic [31:0] MARK_SEQ    = 32'hFFFF_FFFF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic q_push,
  output cmd_t q_cmd,
  input  logic q_full
);

  localparam int SW    = (MAX_SOURCES > 1) ? $clog2(MAX_SOURCES) : 1;
  localparam int PW    = $clog2(WINDOW);
  localparam int SLOTS = MAX_SOURCES * WINDOW;
  localparam int AW    = $clog2(SLOTS);
  localparam int CW    = $clog2(WINDOW + 1);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_CLASS = 2'd1;
  localparam logic [1:0] S_DRAIN = 2'd2;

  logic [1:0]    state_r, state_nxt;
  in_t           item_r;
  logic [SW-1:0] idx_r, idx_in;
  logic [31:0]   exp_r [MAX_SOURCES];
  logic [PW-1:0] pos_r [MAX_SOURCES];
  logic [SLOTS-1:0] occ_r;
  logic [CW-1:0] cnt_r, cnt_nxt;

  logic [31:0]   exp, exp1, d;
  logic [PW-1:0] pos, pos1, ppark;
  logic [PW:0]   psum;
  logic          adv, set_occ, clr_occ, occ_next, occ_park;
  logic [SLOT_AW_MAX-1:0] slot_cur, slot_next, slot_park, occ_addr;

  function automatic logic [SLOT_AW_MAX-1:0] slot_of(logic [SW-1:0] i, logic [PW-1:0] p);
    slot_of = SLOT_AW_MAX'(int'(i) * WINDOW + int'(p));
  endfunction

  function automatic logic [PW-1:0] pos_inc(logic [PW-1:0] p);
    pos_inc = (p == PW'(WINDOW - 1)) ? '0 : p + PW'(1);
  endfunction

  always_comb begin
    idx_in = '0;
    for (int i = 0; i < 16; i++) begin
      if (in_data.source == 4'(i)) idx_in = SW'(i % MAX_SOURCES);
    end
  end

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    exp  = exp_r[idx_r];
    pos  = pos_r[idx_r];
    exp1 = exp + 32'd1;
    // expected wraps at 2^32, so the slot position restarts there
    pos1 = (exp1 == 32'd0) ? '0 : pos_inc(pos);
    d    = item_r.seq - exp;
    psum = {1'b0, pos} + {1'b0, d[PW-1:0]};
    ppark = (psum >= (PW+1)'(WINDOW)) ? PW'(psum - (PW+1)'(WINDOW)) : psum[PW-1:0];
    slot_cur  = slot_of(idx_r, pos);
    slot_next = slot_of(idx_r, pos1);
    slot_park = slot_of(idx_r, ppark);
    occ_next  = occ_r[slot_next[AW-1:0]];
    occ_park  = occ_r[slot_park[AW-1:0]];

    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    adv       = 1'b0;
    set_occ   = 1'b0;
    clr_occ   = 1'b0;
    occ_addr  = slot_park;
    q_push    = 1'b0;
    q_cmd.kind     = K_DELIVER;
    q_cmd.source   = item_r.source;
    q_cmd.handle   = item_r.block_handle;
    q_cmd.is_close = ~item_r.block_valid;
    q_cmd.status   = ST_OK;
    q_cmd.last     = 1'b1;
    q_cmd.slot     = slot_park;

    case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_CLASS;
      end
      S_CLASS: begin
        if (!q_full) begin
          q_push = 1'b1;
          if (item_r.seq == exp || item_r.seq == MARK_SEQ) begin
            adv        = 1'b1;
            q_cmd.last = ~occ_next;
            cnt_nxt    = CW'(1);
            state_nxt  = occ_next ? S_DRAIN : S_IDLE;
          end else if (item_r.seq < exp) begin
            q_cmd.kind   = K_ERROR;
            q_cmd.status = ST_STALE;
            state_nxt    = S_IDLE;
          end else if (d >= 32'(WINDOW)) begin
            q_cmd.kind   = K_ERROR;
            q_cmd.status = ST_BEYOND;
            state_nxt    = S_IDLE;
          end else if (occ_park) begin
            q_cmd.kind   = K_ERROR;
            q_cmd.status = ST_DUPLICATE;
            state_nxt    = S_IDLE;
          end else begin
            q_cmd.kind = K_PARK;
            set_occ    = 1'b1;
            state_nxt  = S_IDLE;
          end
        end
      end
      S_DRAIN: begin
        q_cmd.kind = K_DRAIN;
        q_cmd.slot = slot_cur;
        occ_addr   = slot_cur;
        if (!q_full) begin
          q_push     = 1'b1;
          adv        = 1'b1;
          clr_occ    = 1'b1;
          cnt_nxt    = cnt_r + CW'(1);
          q_cmd.last = (cnt_r + CW'(1) == CW'(WINDOW)) || !occ_next;
          if (q_cmd.last) state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_data;
      idx_r  <= idx_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      occ_r   <= '0;
      for (int i = 0; i < MAX_SOURCES; i++) begin
        exp_r[i] <= '0;
        pos_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      if (adv) begin
        exp_r[idx_r] <= exp1;
        pos_r[idx_r] <= pos1;
      end
      if (set_occ) occ_r[occ_addr[AW-1:0]] <= 1'b1;
      if (clr_occ) occ_r[occ_addr[AW-1:0]] <= 1'b0;
    end
  end

endmodule

// File: rtl/psbr_back.sv
module psbr_back import psbr_pkg::*; #(
  parameter int SLOTS       = 256,
  parameter int HANDLE_BITS = 32
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    q_valid,
  input  cmd_t    q_head,
  output logic    q_pop,
  input  cfg_wr_t cfg,
  output logic    out_valid,
  input  logic    out_ready,
  output out_t    out_data
);

  localparam int AW = $clog2(SLOTS);

  logic [HANDLE_BITS:0] mem_r [SLOTS];
  logic [HANDLE_BITS:0] rd_r;
  cmd_t       s1_r;
  logic       s1_valid_r;
  logic       out_valid_r;
  out_t       out_r;
  logic [4:0] cr_r, cr_nxt;
  logic       adv, is_close, all;
  logic [31:0] handle;

  assign adv   = s1_valid_r && (!out_valid_r || out_ready);
  assign q_pop = q_valid && (!s1_valid_r || adv);

  always_comb begin
    handle   = (s1_r.kind == K_DRAIN) ? 32'(rd_r[HANDLE_BITS-1:0]) : s1_r.handle;
    is_close = (s1_r.kind == K_DRAIN) ? rd_r[HANDLE_BITS] : s1_r.is_close;
    all      = 1'b0;
    cr_nxt   = cr_r;
    if (adv && s1_r.kind != K_ERROR && is_close && cr_r != 5'd0) begin
      cr_nxt = cr_r - 5'd1;
      all    = (cr_r == 5'd1);
    end
    if (cfg.we) cr_nxt = cfg.value;
  end

  // parked words are written at pop, so a later drain reads them back
  always_ff @(posedge clk) begin
    if (q_pop && q_head.kind == K_PARK) begin
      mem_r[q_head.slot[AW-1:0]] <= {q_head.is_close, HANDLE_BITS'(q_head.handle)};
    end
    if (q_pop) rd_r <= mem_r[q_head.slot[AW-1:0]];
    if (q_pop) s1_r <= q_head;
    if (adv) begin
      out_r.out_source     <= s1_r.source;
      out_r.out_handle     <= handle;
      out_r.out_is_close   <= is_close;
      out_r.out_all_closed <= all;
      out_r.out_status     <= s1_r.status;
      out_r.out_last       <= s1_r.last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      cr_r        <= NUM_SOURCES_RST;
    end else begin
      cr_r <= cr_nxt;
      if (q_pop) s1_valid_r <= (q_head.kind != K_PARK);
      else if (adv) s1_valid_r <= 1'b0;
      if (adv) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef SYNTHESIS
  a_no_park_stage: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r |-> s1_r.kind != K_PARK) else $error("park word in output stage");
  a_all_is_close: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (!out_r.out_all_closed || out_r.out_is_close))
    else $error("all_closed without close");
  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.out_status != ST_OK) |-> out_r.out_last && !out_r.out_all_closed)
    else $error("bad error word");
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && !cfg.we) |=> (cr_r == $past(cr_r) || cr_r == $past(cr_r) - 5'd1))
    else $error("close count jumped");
`endif

endmodule

// File: rtl/per_source_block_reorder_top.sv
// per-source block reorder buffer
// in channel: valid/ready words of source, seq, block_valid and block_handle
// out channel: valid/ready words, one per delivered block or per error;
// out_last marks the last word caused by one input word
// a parked (early) word gives no result; an in-order word gives one result
// plus one per block drained from its source's window
// an input word is taken only in idle, after the last one is classified and
// queued; the classify step reads and updates the per-source expected number
// drained words leave at one per cycle while the queue has room, in_ready stays low while a drain runs
// the first result passes the input, queue, stage-1 and output registers to out_valid
// apb register 0 holds num_sources; writing it reloads the close count
// reset: all expected numbers zero, window empty, num_sources 16
// when the receiver stalls, the output register and a short command queue
// fill, then the front stops and in_ready stays low
module per_source_block_reorder_top import psbr_pkg::*; #(
  parameter int          MAX_SOURCES = 16,
  parameter int          WINDOW      = 16,
  parameter logic [31:0] MARK_SEQ    = 32'hFFFF_FFFF,
  parameter int          HANDLE_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_t         in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_t        out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int SLOTS = MAX_SOURCES * WINDOW;

  in_t     in_masked;
  cmd_t    f_cmd, q_head;
  logic    f_push, q_full, q_pop, q_valid;
  cfg_wr_t cfg;
  logic [4:0] ns_r;

  assign pready  = 1'b1;
  assign cfg.we    = psel && penable && pwrite && (paddr == ADDR_NUM_SOURCES);
  assign cfg.value = pwdata[4:0];
  assign prdata  = (paddr == ADDR_NUM_SOURCES) ? 32'(ns_r) : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ns_r <= NUM_SOURCES_RST;
    end else if (cfg.we) begin
      ns_r <= cfg.value;
    end
  end

  always_comb begin
    in_masked = in_data;
    if (HANDLE_BITS < 32) begin
      in_masked.block_handle = in_data.block_handle & ~(32'hFFFF_FFFF << HANDLE_BITS);
    end
  end

  psbr_front #(
    .MAX_SOURCES(MAX_SOURCES),
    .WINDOW(WINDOW),
    .MARK_SEQ(MARK_SEQ)
  ) u_front (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_masked),
    .q_push(f_push),
    .q_cmd(f_cmd),
    .q_full(q_full)
  );

  psbr_queue u_queue (
    .clk(clk),
    .rst_n(rst_n),
    .push(f_push),
    .push_cmd(f_cmd),
    .full(q_full),
    .pop(q_pop),
    .not_empty(q_valid),
    .head(q_head)
  );

  psbr_back #(
    .SLOTS(SLOTS),
    .HANDLE_BITS(HANDLE_BITS)
  ) u_back (
    .clk(clk),
    .rst_n(rst_n),
    .q_valid(q_valid),
    .q_head(q_head),
    .q_pop(q_pop),
    .cfg(cfg),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data)
  );

endmodule

// File: tb/sv/tb_per_source_block_reorder_top.sv
`timescale 1ns / 1ps

module tb_per_source_block_reorder_top;
  import psbr_pkg::*;

  localparam int NSRC = 16;
  localparam int WIN = 16;
  localparam logic [31:0] FINAL_MARK = 32'hFFFF_FFFF;
  localparam int CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_fire = 1'b0;

  always #2 clk = ~clk;

  per_source_block_reorder_top DUT (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .in_data(in_data), .out_valid(out_valid), .out_ready(out_ready),
    .out_data(out_data), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // predictor state
  logic [31:0] next_seq [NSRC];
  logic [31:0] park_handle [NSRC*WIN];
  logic park_close [NSRC*WIN];
  logic park_used [NSRC*WIN];
  logic [4:0] closes_left;

  in_t pending_words[$];
  out_t expected_words[$];
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int mismatches = 0;
  int words_sent = 0;
  int results_seen = 0;
  int cycles = 0;

  function automatic out_t deliver_block(logic [3:0] src, logic [31:0] hnd, logic cl);
    out_t r;
    r = '0;
    r.out_source = src;
    r.out_handle = hnd;
    r.out_is_close = cl;
    r.out_status = ST_OK;
    if (cl && closes_left != 0) begin
      closes_left = closes_left - 5'd1;
      r.out_all_closed = (closes_left == 0);
    end
    next_seq[src] = next_seq[src] + 32'd1;
    return r;
  endfunction

  task automatic predict_word(in_t w);
    out_t r;
    logic cl;
    logic [31:0] gap;
    int slot;
    cl = ~w.block_valid;
    if (w.seq == next_seq[w.source] || w.seq == FINAL_MARK) begin
      r = deliver_block(w.source, w.block_handle, cl);
      for (int n = 1; n < WIN; n++) begin
        slot = w.source * WIN + next_seq[w.source][3:0];
        if (!park_used[slot]) break;
        park_used[slot] = 1'b0;
        expected_words.push_back(r);
        r = deliver_block(w.source, park_handle[slot], park_close[slot]);
      end
      r.out_last = 1'b1;
      expected_words.push_back(r);
    end else begin
      gap = w.seq - next_seq[w.source];
      slot = w.source * WIN + w.seq[3:0];
      r = '0;
      r.out_source = w.source;
      r.out_handle = w.block_handle;
      r.out_is_close = cl;
      r.out_last = 1'b1;
      if (w.seq < next_seq[w.source]) r.out_status = ST_STALE;
      else if (gap >= WIN) r.out_status = ST_BEYOND;
      else if (park_used[slot]) r.out_status = ST_DUPLICATE;
      else begin
        park_used[slot] = 1'b1;
        park_handle[slot] = w.block_handle;
        park_close[slot] = cl;
        return;
      end
      expected_words.push_back(r);
    end
  endtask

  // driver
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_valid || in_fire) begin
        if (pending_words.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_data <= pending_words.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // monitor and predictor, both on the accepting edge
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("tb_per_source_block_reorder_top: FAIL");
      $finish;
    end
    in_fire = rst_n && in_valid && in_ready;
    if (in_fire) begin
      predict_word(in_data);
      words_sent++;
    end
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (expected_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word %h", out_data);
      end else if (out_data !== expected_words[0]) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected %h actual %h", expected_words[0], out_data);
        void'(expected_words.pop_front());
      end else begin
        void'(expected_words.pop_front());
      end
    end
  end

  task automatic wait_drained();
    while (pending_words.size() > 0 || in_valid || expected_words.size() > 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_num_sources(logic [4:0] v);
    @(negedge clk);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= ADDR_NUM_SOURCES; pwdata <= {27'd0, v};
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    closes_left = v;
    if (prdata !== {27'd0, v} || pready !== 1'b1) begin
      mismatches++;
      if (mismatches <= 10)
        $display("register readback: expected %h actual %h", {27'd0, v}, prdata);
    end
  endtask

  function automatic in_t make_word(logic [3:0] src, logic [31:0] sq, logic bv,
                                    logic [31:0] hnd);
    in_t w;
    w.source = src; w.seq = sq; w.block_valid = bv; w.block_handle = hnd;
    return w;
  endfunction

  // a scrambled run of in-order blocks for one source, with a chance of noise
  task automatic queue_burst(logic [3:0] src, int len, logic [31:0] base);
    int order[$];
    int j;
    logic [31:0] tmp;
    for (int i = 0; i < len; i++) order.push_back(i);
    order.shuffle();
    foreach (order[i]) begin
      pending_words.push_back(make_word(src, base + order[i], $urandom_range(9) != 0,
                                        $urandom()));
      if ($urandom_range(9) == 0) begin
        j = $urandom_range(3);
        tmp = (j == 0) ? base - 1 - $urandom_range(3) :
              (j == 1) ? base + WIN + $urandom_range(40) :
              (j == 2) ? base + order[i] : $urandom();
        pending_words.push_back(make_word(src, tmp, 1'($urandom_range(1)), $urandom()));
      end
    end
  endtask

  logic [31:0] base_seq [NSRC];
  logic [4:0] cfg_values [4] = '{5'd1, 5'd16, 5'd3, 5'd0};
  logic [3:0] s;
  int blen;

  // bursts are queued ahead of prediction, so track each source's queued position
  function automatic logic [31:0] next_seq_hint(logic [3:0] src, int len);
    logic [31:0] b;
    b = base_seq[src];
    base_seq[src] = base_seq[src] + 32'(len);
    return b;
  endfunction

  initial begin
    foreach (next_seq[i]) begin next_seq[i] = '0; base_seq[i] = '0; end
    foreach (park_used[i]) begin
      park_used[i] = 1'b0; park_handle[i] = '0; park_close[i] = 1'b0;
    end
    closes_left = NUM_SOURCES_RST;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: in order, early parking with full drain, errors, final marker, closes
    pending_words.push_back(make_word(4'd0, 32'd0, 1'b1, 32'h0000_0000));
    pending_words.push_back(make_word(4'd0, 32'd0, 1'b1, 32'hFFFF_FFFF));
    for (int i = 15; i >= 2; i--)
      pending_words.push_back(make_word(4'd1, i, i[0], 32'hA500_0000 + i));
    pending_words.push_back(make_word(4'd1, 32'd5, 1'b1, 32'h1234_5678));
    pending_words.push_back(make_word(4'd1, 32'd17, 1'b1, 32'h5555_AAAA));
    pending_words.push_back(make_word(4'd1, 32'd0, 1'b1, 32'hAAAA_5555));
    pending_words.push_back(make_word(4'd1, 32'd1, 1'b0, 32'h0F0F_F0F0));
    pending_words.push_back(make_word(4'd15, FINAL_MARK, 1'b0, 32'hFFFF_FFFF));
    pending_words.push_back(make_word(4'd2, 32'h8000_0000, 1'b1, 32'd1));
    wait_drained();
    for (int i = 0; i < NSRC; i++) base_seq[i] = next_seq[i];

    // random phases, a new close count each time
    for (int ph = 0; ph < 4; ph++) begin
      write_num_sources(cfg_values[ph]);
      send_idle_pct = (ph == 0) ? 25 : (ph == 1) ? 59 : 0;
      recv_idle_pct = (ph == 0) ? 59 : (ph == 1) ? 25 : 0;
      if (ph == 3) begin
        // the final marker advances the expected number like an in-order block
        pending_words.push_back(make_word(4'd3, FINAL_MARK, 1'b1, $urandom()));
        base_seq[3] = base_seq[3] + 32'd1;
      end
      while (pending_words.size() < 48) begin
        s = 4'($urandom_range(NSRC - 1));
        blen = $urandom_range(1, 12);
        queue_burst(s, blen, next_seq_hint(s, blen));
      end
      wait_drained();
      for (int i = 0; i < NSRC; i++) base_seq[i] = next_seq[i];
    end

    $display("sent %0d words, checked %0d results over 4 close-count settings",
             words_sent, results_seen);
    $display("covered parking, drains, stale, beyond-window, duplicate and final blocks");
    if (mismatches == 0 && expected_words.size() == 0) begin
      $display("tb_per_source_block_reorder_top: PASS");
    end else begin
      $display("tb_per_source_block_reorder_top: FAIL");
    end
    $finish;
  end

endmodule
